// ----- sv/fqs_pkg.sv -----
// ----------------------------------------------------------------------------
// FIFO queue with search: shared package
// Depth, field widths, command and status codes, and the sequencer states.
// ----------------------------------------------------------------------------
package fqs_pkg;

    localparam int DEPTH   = 8;
    localparam int WORD_W  = 32;
    localparam int OCC_W   = 4;
    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);

    localparam int MIN_START  = 999999;
    localparam int MAX_START  = 0;
    localparam int EMPTY_WORD = 32;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [PTR_W-1:0]         ptr_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic [OCC_W-1:0]         occ_t;

    typedef enum logic [1:0] {
        CMD_ENQ    = 2'd0,
        CMD_DEQ    = 2'd1,
        CMD_MINMAX = 2'd2,
        CMD_SEARCH = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DEQ_WAIT,
        S_SCAN
    } state_t;

    typedef struct packed {
        logic clear;
        logic step;
    } scan_ctl_t;

    function automatic ptr_t next_ptr(ptr_t p);
        return (p == ptr_t'(DEPTH - 1)) ? '0 : p + ptr_t'(1);
    endfunction

endpackage

// ----- sv/fqs_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- sv/fqs_cmp_unit.sv -----
// ----------------------------------------------------------------------------
// FIFO queue with search: scan compare unit
// Folds one stored word per step into the running minimum, maximum and
// match flag.
// ----------------------------------------------------------------------------
module fqs_cmp_unit (
    input  logic              clk,
    input  fqs_pkg::scan_ctl_t ctl,
    input  fqs_pkg::word_t    data,
    input  fqs_pkg::word_t    key,
    output fqs_pkg::word_t    lo,
    output fqs_pkg::word_t    hi,
    output logic              found
);

    fqs_pkg::word_t lo_reg;
    fqs_pkg::word_t hi_reg;
    logic           found_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.clear)
        begin
            lo_reg    <= fqs_pkg::word_t'(fqs_pkg::MIN_START);
            hi_reg    <= fqs_pkg::word_t'(fqs_pkg::MAX_START);
            found_reg <= 1'b0;
        end
        else if (ctl.step)
        begin
            if (data < lo_reg)
            begin
                lo_reg <= data;
            end
            if (data > hi_reg)
            begin
                hi_reg <= data;
            end
            if (data == key)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    assign lo    = lo_reg;
    assign hi    = hi_reg;
    assign found = found_reg;

endmodule

// ----- sv/fifo_queue_with_search.sv -----
// ----------------------------------------------------------------------------
// FIFO queue with search
// Bounded queue of signed words with enqueue, dequeue, min/max scan and
// value search, run by a small sequencer over one RAM and one compare unit.
// ----------------------------------------------------------------------------
// Channel   Handshake              Payload
// command   start, busy            cmd, value_in
// result    done (one-cycle)       value_out, min_value, max_value, found,
//                                  status, occupancy
//
// A transfer of a command takes place at a clock edge with start high and
// busy low. The result strobe done is registered: enqueue and dequeue from an
// empty queue raise it from the execute state, dequeue from a wait state that
// takes the registered RAM read data, and min/max and search at the end of a
// scan, set by the single RAM read port that delivers one stored word per cycle
// to the compare unit with registered read data.
// Reset is asynchronous and clears the head and tail pointers and the fill count; the
// storage is not cleared. The receiver cannot stall; start is ignored while
// busy is high.
// ----------------------------------------------------------------------------
module fifo_queue_with_search (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         cmd,
    input  logic signed [31:0] value_in,
    output logic               done,
    output logic signed [31:0] value_out,
    output logic signed [31:0] min_value,
    output logic signed [31:0] max_value,
    output logic               found,
    output logic [1:0]         status,
    output logic [3:0]         occupancy
);

    fqs_pkg::state_t    state_reg;
    fqs_pkg::state_t    state_next;
    fqs_pkg::cmd_t      cmd_reg;
    fqs_pkg::word_t     word_reg;
    fqs_pkg::ptr_t      head_reg;
    fqs_pkg::ptr_t      tail_reg;
    fqs_pkg::ptr_t      ptr_reg;
    fqs_pkg::cnt_t      fill_reg;
    fqs_pkg::cnt_t      issue_reg;
    logic               rd_valid_reg;

    logic               done_reg;
    fqs_pkg::word_t     value_out_reg;
    fqs_pkg::word_t     min_reg;
    fqs_pkg::word_t     max_reg;
    logic               found_reg;
    fqs_pkg::status_t   status_reg;
    fqs_pkg::cnt_t      occ_reg;

    logic               full;
    logic               empty;
    logic               accept;
    logic               scan_last;
    logic               ram_we;
    logic               ram_re;
    fqs_pkg::ptr_t      ram_raddr;
    fqs_pkg::word_t     ram_rdata;
    fqs_pkg::scan_ctl_t scan_ctl;
    fqs_pkg::word_t     unit_lo;
    fqs_pkg::word_t     unit_hi;
    logic               unit_found;

    assign full      = (fill_reg == fqs_pkg::cnt_t'(fqs_pkg::DEPTH));
    assign empty     = (fill_reg == '0);
    assign accept    = start && (state_reg == fqs_pkg::S_IDLE);
    assign scan_last = (issue_reg == fill_reg) && !rd_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fqs_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = fqs_pkg::S_EXEC;
                end
            end
            fqs_pkg::S_EXEC:
            begin
                unique case (cmd_reg) inside
                    fqs_pkg::CMD_ENQ:
                    begin
                        state_next = fqs_pkg::S_IDLE;
                    end
                    fqs_pkg::CMD_DEQ:
                    begin
                        state_next = empty ? fqs_pkg::S_IDLE : fqs_pkg::S_DEQ_WAIT;
                    end
                    fqs_pkg::CMD_MINMAX, fqs_pkg::CMD_SEARCH:
                    begin
                        state_next = fqs_pkg::S_SCAN;
                    end
                    default:
                    begin
                        state_next = fqs_pkg::S_IDLE;
                    end
                endcase
            end
            fqs_pkg::S_DEQ_WAIT:
            begin
                state_next = fqs_pkg::S_IDLE;
            end
            fqs_pkg::S_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = fqs_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fqs_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy           = (state_reg != fqs_pkg::S_IDLE);
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_raddr      = ptr_reg;
        scan_ctl.clear = 1'b0;
        scan_ctl.step  = 1'b0;
        unique case (state_reg)
            fqs_pkg::S_IDLE:
            begin
            end
            fqs_pkg::S_EXEC:
            begin
                ram_we         = (cmd_reg == fqs_pkg::CMD_ENQ) && !full;
                ram_re         = (cmd_reg == fqs_pkg::CMD_DEQ) && !empty;
                ram_raddr      = head_reg;
                scan_ctl.clear = 1'b1;
            end
            fqs_pkg::S_DEQ_WAIT:
            begin
            end
            fqs_pkg::S_SCAN:
            begin
                ram_re        = (issue_reg < fill_reg);
                scan_ctl.step = rd_valid_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= fqs_pkg::S_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            fill_reg     <= '0;
            issue_reg    <= '0;
            rd_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= (state_reg == fqs_pkg::S_SCAN) && ram_re;
            done_reg     <= 1'b0;
            if (state_reg == fqs_pkg::S_EXEC)
            begin
                issue_reg <= '0;
                if (cmd_reg == fqs_pkg::CMD_ENQ)
                begin
                    done_reg <= 1'b1;
                    if (!full)
                    begin
                        tail_reg <= fqs_pkg::next_ptr(tail_reg);
                        fill_reg <= fill_reg + fqs_pkg::cnt_t'(1);
                    end
                end
                else if (cmd_reg == fqs_pkg::CMD_DEQ && empty)
                begin
                    done_reg <= 1'b1;
                end
            end
            if (state_reg == fqs_pkg::S_DEQ_WAIT)
            begin
                done_reg <= 1'b1;
                head_reg <= fqs_pkg::next_ptr(head_reg);
                fill_reg <= fill_reg - fqs_pkg::cnt_t'(1);
            end
            if (state_reg == fqs_pkg::S_SCAN)
            begin
                if (ram_re)
                begin
                    issue_reg <= issue_reg + fqs_pkg::cnt_t'(1);
                end
                if (scan_last)
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= fqs_pkg::cmd_t'(cmd);
            word_reg <= value_in;
        end
        if (state_reg == fqs_pkg::S_EXEC)
        begin
            ptr_reg <= head_reg;
        end
        else if (state_reg == fqs_pkg::S_SCAN && ram_re)
        begin
            ptr_reg <= fqs_pkg::next_ptr(ptr_reg);
        end

        if (state_reg == fqs_pkg::S_EXEC && cmd_reg == fqs_pkg::CMD_ENQ)
        begin
            value_out_reg <= '0;
            min_reg       <= '0;
            max_reg       <= '0;
            found_reg     <= 1'b0;
            status_reg    <= full ? fqs_pkg::ST_FULL : fqs_pkg::ST_OK;
            occ_reg       <= full ? fill_reg : fill_reg + fqs_pkg::cnt_t'(1);
        end
        else if (state_reg == fqs_pkg::S_EXEC && cmd_reg == fqs_pkg::CMD_DEQ && empty)
        begin
            value_out_reg <= fqs_pkg::word_t'(fqs_pkg::EMPTY_WORD);
            min_reg       <= '0;
            max_reg       <= '0;
            found_reg     <= 1'b0;
            status_reg    <= fqs_pkg::ST_EMPTY;
            occ_reg       <= fill_reg;
        end
        else if (state_reg == fqs_pkg::S_DEQ_WAIT)
        begin
            value_out_reg <= ram_rdata;
            min_reg       <= '0;
            max_reg       <= '0;
            found_reg     <= 1'b0;
            status_reg    <= fqs_pkg::ST_OK;
            occ_reg       <= fill_reg - fqs_pkg::cnt_t'(1);
        end
        else if (state_reg == fqs_pkg::S_SCAN && scan_last)
        begin
            value_out_reg <= '0;
            status_reg    <= fqs_pkg::ST_OK;
            occ_reg       <= fill_reg;
            if (cmd_reg == fqs_pkg::CMD_MINMAX)
            begin
                min_reg   <= unit_lo;
                max_reg   <= unit_hi;
                found_reg <= 1'b0;
            end
            else
            begin
                min_reg   <= '0;
                max_reg   <= '0;
                found_reg <= unit_found;
            end
        end
    end

    fqs_ram #(
        .WIDTH (fqs_pkg::WORD_W),
        .DEPTH (fqs_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (word_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    fqs_cmp_unit u_cmp (
        .clk   (clk),
        .ctl   (scan_ctl),
        .data  (ram_rdata),
        .key   (word_reg),
        .lo    (unit_lo),
        .hi    (unit_hi),
        .found (unit_found)
    );

    assign done      = done_reg;
    assign value_out = value_out_reg;
    assign min_value = min_reg;
    assign max_value = max_reg;
    assign found     = found_reg;
    assign status    = status_reg;
    assign occupancy = fqs_pkg::occ_t'(occ_reg);

endmodule

// ----- sv/fqs_checker.sv -----
// ----------------------------------------------------------------------------
// FIFO queue with search: port checker
// Concurrent assertions on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
module fqs_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic signed [31:0] value_out,
    input logic [1:0]         status,
    input logic [3:0]         occupancy
);

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("command transfer not followed by busy");

    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == fqs_pkg::ST_FULL) |->
            (occupancy == fqs_pkg::occ_t'(fqs_pkg::DEPTH)))
        else $error("full status with queue not full");

    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == fqs_pkg::ST_EMPTY) |->
            (occupancy == '0 && value_out == fqs_pkg::word_t'(fqs_pkg::EMPTY_WORD)))
        else $error("empty status with wrong occupancy or value");

endmodule

bind fifo_queue_with_search fqs_checker u_checker (.*);

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the FIFO queue with search
// Sends commands over the start/busy handshake and checks each one-cycle
// result against a software copy of the queue. The run starts with directed
// cases: empty queue, all-negative and all-large contents, and a full queue.
// It then runs biased random traffic with random sender gaps and short
// bursts without gaps. Each random phase ends with a pause until every
// result has arrived.
// ----------------------------------------------------------------------------
module tb;

    import fqs_pkg::*;

    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_ITEMS  = 150;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        word_t      value_out;
        word_t      min_value;
        word_t      max_value;
        logic       found;
        logic [1:0] status;
        occ_t       occupancy;
    } reply_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         start = 1'b0;
    logic         busy;
    cmd_t         cmd = CMD_ENQ;
    word_t        value_in = '0;
    logic         done;
    word_t        value_out;
    word_t        min_value;
    word_t        max_value;
    logic         found;
    logic [1:0]   status;
    logic [3:0]   occupancy;

    word_t        held_words [DEPTH];
    int           head_slot = 0;
    int           tail_slot = 0;
    int           held = 0;

    reply_t       expected_replies [$];
    reply_t       got_reply;
    reply_t       want_reply;

    int           burst_left = 0;
    int           mismatches = 0;
    int           replies_checked = 0;
    int           cmd_count [4] = '{0, 0, 0, 0};
    int           full_rejects = 0;
    int           empty_dequeues = 0;
    int           search_hits = 0;
    int           idle_cycles = 0;

    fifo_queue_with_search u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .value_in  (value_in),
        .done      (done),
        .value_out (value_out),
        .min_value (min_value),
        .max_value (max_value),
        .found     (found),
        .status    (status),
        .occupancy (occupancy)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic reply_t apply_queue_command(cmd_t c, word_t v);
        reply_t r;
        int     lo;
        int     hi;
        int     p;
        int     i;
        r.value_out = '0;
        r.min_value = '0;
        r.max_value = '0;
        r.found     = 1'b0;
        r.status    = ST_OK;
        cmd_count[c]++;
        case (c)
            CMD_ENQ:
            begin
                if (held == DEPTH)
                begin
                    r.status = ST_FULL;
                    full_rejects++;
                end
                else
                begin
                    held_words[tail_slot] = v;
                    tail_slot = (tail_slot + 1) % DEPTH;
                    held++;
                end
            end
            CMD_DEQ:
            begin
                if (held == 0)
                begin
                    r.value_out = EMPTY_WORD;
                    r.status    = ST_EMPTY;
                    empty_dequeues++;
                end
                else
                begin
                    r.value_out = held_words[head_slot];
                    head_slot = (head_slot + 1) % DEPTH;
                    held--;
                end
            end
            CMD_MINMAX:
            begin
                lo = MIN_START;
                hi = MAX_START;
                p  = head_slot;
                for (i = 0; i < held; i++)
                begin
                    if (held_words[p] < lo)
                        lo = held_words[p];
                    if (held_words[p] > hi)
                        hi = held_words[p];
                    p = (p + 1) % DEPTH;
                end
                r.min_value = lo;
                r.max_value = hi;
            end
            default:
            begin
                p = head_slot;
                for (i = 0; i < held; i++)
                begin
                    if (held_words[p] == v)
                        r.found = 1'b1;
                    p = (p + 1) % DEPTH;
                end
                if (r.found)
                    search_hits++;
            end
        endcase
        r.occupancy = occ_t'(held);
        return r;
    endfunction

    function automatic word_t pick_word();
        case ($urandom_range(0, 9))
            0: return word_t'(32'h8000_0000);
            1: return word_t'(32'h7fff_ffff);
            2:
            begin
                case ($urandom_range(0, 5))
                    0: return word_t'(999999);
                    1: return word_t'(1000000);
                    2: return word_t'(999998);
                    3: return word_t'(-1);
                    4: return word_t'(0);
                    default: return word_t'(EMPTY_WORD);
                endcase
            end
            3, 4, 5: return word_t'($urandom_range(0, 40)) - word_t'(20);
            default: return word_t'($urandom);
        endcase
    endfunction

    // Leaves start high after the transfer so that a following command with
    // no gap keeps it high without a second assignment in the same step.
    task automatic send_command(input cmd_t c, input word_t v);
        int gap;
        if (burst_left > 0)
        begin
            gap = 0;
            burst_left--;
        end
        else
        begin
            gap = $urandom_range(0, 18);
            if ($urandom_range(0, 19) == 0)
                burst_left = $urandom_range(5, 30);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        cmd      <= c;
        value_in <= v;
        do
            @(posedge clk);
        while (busy);
        expected_replies.push_back(apply_queue_command(c, v));
    endtask

    task automatic pause_until_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (expected_replies.size() != 0);
    endtask

    task automatic test_empty_queue();
        send_command(CMD_DEQ, word_t'(7));
        send_command(CMD_MINMAX, word_t'(0));
        send_command(CMD_SEARCH, word_t'(0));
    endtask

    task automatic test_negative_words();
        send_command(CMD_ENQ, word_t'(-5));
        send_command(CMD_ENQ, word_t'(32'h8000_0000));
        send_command(CMD_MINMAX, word_t'(0));
        send_command(CMD_DEQ, word_t'(0));
        send_command(CMD_DEQ, word_t'(0));
    endtask

    task automatic test_large_words();
        send_command(CMD_ENQ, word_t'(32'h7fff_ffff));
        send_command(CMD_ENQ, word_t'(1000000));
        send_command(CMD_MINMAX, word_t'(0));
        send_command(CMD_SEARCH, word_t'(32'h7fff_ffff));
        send_command(CMD_SEARCH, word_t'(999999));
    endtask

    task automatic test_full_queue();
        send_command(CMD_ENQ, word_t'(-1));
        send_command(CMD_ENQ, word_t'(0));
        send_command(CMD_ENQ, word_t'(EMPTY_WORD));
        send_command(CMD_ENQ, word_t'(999999));
        send_command(CMD_ENQ, word_t'(1));
        send_command(CMD_ENQ, word_t'(32'h5555_aaaa));
        send_command(CMD_ENQ, word_t'(32'haaaa_5555));
        send_command(CMD_MINMAX, word_t'(0));
    endtask

    task automatic test_random_traffic();
        int    enq_weight [6] = '{55, 25, 40, 60, 20, 35};
        int    deq_weight [6] = '{20, 50, 30, 15, 55, 30};
        int    phase;
        int    n;
        int    r;
        word_t v;
        for (phase = 0; phase < 6; phase++)
        begin
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < enq_weight[phase])
                    send_command(CMD_ENQ, pick_word());
                else if (r < enq_weight[phase] + deq_weight[phase])
                    send_command(CMD_DEQ, word_t'($urandom));
                else if (r % 2 == 0)
                    send_command(CMD_MINMAX, word_t'($urandom));
                else
                begin
                    if (held > 0 && $urandom_range(0, 1) == 1)
                        v = held_words[(head_slot + $urandom_range(0, held - 1)) % DEPTH];
                    else
                        v = pick_word();
                    send_command(CMD_SEARCH, v);
                end
            end
            pause_until_drained();
        end
    endtask

    task automatic note_mismatch(input string why, input reply_t want, input reply_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
        begin
            $display("%0t: %s", $realtime, why);
            $display("    expected value_out=%0d min=%0d max=%0d found=%0b status=%0d occ=%0d",
                     want.value_out, want.min_value, want.max_value, want.found,
                     want.status, want.occupancy);
            $display("    actual   value_out=%0d min=%0d max=%0d found=%0b status=%0d occ=%0d",
                     got.value_out, got.min_value, got.max_value, got.found,
                     got.status, got.occupancy);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            got_reply.value_out = value_out;
            got_reply.min_value = min_value;
            got_reply.max_value = max_value;
            got_reply.found     = found;
            got_reply.status    = status;
            got_reply.occupancy = occupancy;
            if (expected_replies.size() == 0)
            begin
                want_reply = '{default: '0};
                note_mismatch("result transfer with no command pending", want_reply, got_reply);
            end
            else
            begin
                want_reply = expected_replies.pop_front();
                replies_checked++;
                if (got_reply.value_out !== want_reply.value_out ||
                    got_reply.min_value !== want_reply.min_value ||
                    got_reply.max_value !== want_reply.max_value ||
                    got_reply.found     !== want_reply.found     ||
                    got_reply.status    !== want_reply.status    ||
                    got_reply.occupancy !== want_reply.occupancy)
                    note_mismatch("result mismatch", want_reply, got_reply);
            end
        end
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Timeout: no transfer for %0d cycles.", IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_empty_queue();
        test_negative_words();
        test_large_words();
        test_full_queue();
        pause_until_drained();
        test_random_traffic();
        pause_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d enqueue, %0d dequeue, %0d min/max and %0d search commands; %0d results checked.",
                 cmd_count[CMD_ENQ], cmd_count[CMD_DEQ], cmd_count[CMD_MINMAX],
                 cmd_count[CMD_SEARCH], replies_checked);
        $display("Saw %0d full rejects, %0d empty dequeues and %0d search hits; %0d mismatches.",
                 full_rejects, empty_dequeues, search_hits, mismatches);
        if (mismatches == 0 && expected_replies.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
